/* hw/rtl/avsd_pkg.sv */
// Shared types, codes and field layout tables for the AIS VDM decoder.
// No dependencies.
package avsd_pkg;

  localparam logic [1:0] KIND_MSG18  = 2'd0;
  localparam logic [1:0] KIND_MSG24A = 2'd1;
  localparam logic [1:0] KIND_MSG24B = 2'd2;

  localparam logic [5:0] MSG_ID_18 = 6'd18;
  localparam logic [5:0] MSG_ID_24 = 6'd24;

  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_V      = 8'h56;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_M      = 8'h4D;

  localparam int ACC_W = 36;  // six sextets

  // Where one field sits in the sextet stream.
  typedef struct packed {
    logic [4:0] first;  // first sextet
    logic [2:0] nsext;  // sextets to read
    logic [2:0] pad;    // bits below the field in the last sextet
    logic [4:0] len;
    logic       sgn;
    logic       chr;    // six-bit name character
  } fld_desc_t;

  function automatic logic [5:0] dearmor(input logic [7:0] c);
    logic [9:0] t;
    t = {2'b00, c} + 10'd40;
    t = (t > 10'd128) ? t + 10'd32 : t + 10'd40;
    return t[5:0];
  endfunction

  function automatic logic [7:0] hdr_char(input logic [2:0] pos);
    logic [7:0] r;
    unique case (pos)
      3'd1:    r = CH_A;
      3'd2:    r = CH_I;
      3'd3:    r = CH_V;
      3'd4:    r = CH_D;
      3'd5:    r = CH_M;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] field_count(input logic [1:0] kind);
    logic [4:0] r;
    unique case (kind)
      KIND_MSG18:  r = 5'd21;
      KIND_MSG24A: r = 5'd24;
      default:     r = 5'd5;
    endcase
    return r;
  endfunction

  function automatic fld_desc_t mk(input int first, input int n, input int pad,
                                   input int len, input logic sgn, input logic chr);
    fld_desc_t d;
    d.first = 5'(first);
    d.nsext = 3'(n);
    d.pad   = 3'(pad);
    d.len   = 5'(len);
    d.sgn   = sgn;
    d.chr   = chr;
    return d;
  endfunction

  function automatic fld_desc_t field_desc(input logic [1:0] kind, input logic [4:0] idx);
    fld_desc_t d;
    d = mk(0, 1, 0, 6, 1'b0, 1'b0);
    if (idx == 5'd1) d = mk(1, 1, 4, 2, 1'b0, 1'b0);
    else if (idx == 5'd2) d = mk(1, 6, 4, 30, 1'b0, 1'b0);
    else if (idx != 5'd0) begin
      if (kind == KIND_MSG18) begin
        case (idx)
          5'd3:    d = mk(6, 2, 2, 8, 1'b0, 1'b0);
          5'd4:    d = mk(7, 3, 4, 10, 1'b0, 1'b0);
          5'd5:    d = mk(9, 1, 3, 1, 1'b0, 1'b0);
          5'd6:    d = mk(9, 6, 5, 28, 1'b1, 1'b0);
          5'd7:    d = mk(14, 5, 2, 27, 1'b1, 1'b0);
          5'd8:    d = mk(18, 3, 2, 12, 1'b0, 1'b0);
          5'd9:    d = mk(20, 3, 5, 9, 1'b0, 1'b0);
          5'd10:   d = mk(22, 2, 5, 6, 1'b0, 1'b0);
          5'd11:   d = mk(23, 1, 3, 2, 1'b0, 1'b0);
          5'd12:   d = mk(23, 1, 2, 1, 1'b0, 1'b0);
          5'd13:   d = mk(23, 1, 1, 1, 1'b0, 1'b0);
          5'd14:   d = mk(23, 1, 0, 1, 1'b0, 1'b0);
          5'd15:   d = mk(24, 1, 5, 1, 1'b0, 1'b0);
          5'd16:   d = mk(24, 1, 4, 1, 1'b0, 1'b0);
          5'd17:   d = mk(24, 1, 3, 1, 1'b0, 1'b0);
          5'd18:   d = mk(24, 1, 2, 1, 1'b0, 1'b0);
          5'd19:   d = mk(24, 1, 1, 1, 1'b0, 1'b0);
          default: d = mk(24, 4, 0, 19, 1'b0, 1'b0);
        endcase
      end else if (idx == 5'd3) begin
        d = mk(6, 1, 2, 2, 1'b0, 1'b0);
      end else if (kind == KIND_MSG24B) begin
        d = mk(6, 2, 0, 8, 1'b0, 1'b0);
      end else begin
        // name character idx-4 starts at sextet idx+2, in its last two bits
        d = mk(0, 2, 2, 6, 1'b0, 1'b1);
        d.first = idx + 5'd2;
      end
    end
    return d;
  endfunction

endpackage

/* hw/rtl/avsd_parser.sv */
// Sentence header check, comma count and payload de-armoring.
// Depends on avsd_pkg.
module avsd_parser import avsd_pkg::*; #(
  parameter int P  = 28,
  parameter int AW = 5,
  parameter int CW = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [7:0]    char_byte,
  input  logic          sentence_start,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [5:0]    wr_data,
  output logic [CW-1:0] fill,
  output logic          go
);

  typedef enum logic [2:0] {PH_IDLE, PH_HEADER, PH_FIELDS, PH_PAYLOAD, PH_DONE} phase_t;

  phase_t        phase_r, phase_nxt, ph_eff;
  logic [2:0]    pos_r, pos_nxt, pos_eff;
  logic [2:0]    comma_r, comma_nxt, comma_eff;
  logic [CW-1:0] cnt_r, cnt_nxt, cnt_eff;
  logic          hdr_ok, is_comma;

  assign ph_eff    = sentence_start ? PH_HEADER : phase_r;
  assign pos_eff   = sentence_start ? 3'd0 : pos_r;
  assign comma_eff = sentence_start ? 3'd0 : comma_r;
  assign cnt_eff   = sentence_start ? '0 : cnt_r;
  assign is_comma  = (char_byte == CH_COMMA);
  assign hdr_ok    = (pos_eff == 3'd0) ? (char_byte == CH_BANG || char_byte == CH_DOLLAR)
                                       : (char_byte == hdr_char(pos_eff));

  always_comb begin
    phase_nxt = ph_eff;
    pos_nxt   = pos_eff;
    comma_nxt = comma_eff;
    cnt_nxt   = cnt_eff;
    wr_en     = 1'b0;
    go        = 1'b0;
    unique case (ph_eff)
      PH_HEADER: begin
        if (!hdr_ok) phase_nxt = PH_DONE;
        else begin
          pos_nxt = pos_eff + 3'd1;
          if (pos_eff == 3'd5) phase_nxt = PH_FIELDS;
        end
      end
      PH_FIELDS: begin
        if (is_comma) begin
          comma_nxt = comma_eff + 3'd1;
          if (comma_eff == 3'd4) phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (!is_comma) begin
          if (cnt_eff < CW'(P)) begin
            wr_en   = accept;
            cnt_nxt = cnt_eff + CW'(1);
          end
        end else begin
          comma_nxt = comma_eff + 3'd1;
          phase_nxt = PH_DONE;
          go        = accept;
        end
      end
      default: ;
    endcase
  end

  assign wr_addr = AW'(cnt_eff);
  assign wr_data = dearmor(char_byte);
  assign fill    = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pos_r   <= '0;
      comma_r <= '0;
      cnt_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      comma_r <= comma_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

/* hw/rtl/avsd_store.sv */
// Sextet memory, one write and one registered read port.
// Entries at or past the fill count read as zero. Depends on nothing.
module avsd_store #(
  parameter int P  = 28,
  parameter int AW = 5,
  parameter int CW = 5
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [5:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  input  logic [CW-1:0] fill,
  output logic [5:0]    rd_data
);

  logic [5:0] mem [P];
  logic [5:0] q_r;
  logic       hit_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    q_r   <= mem[rd_addr];
    hit_r <= (CW'(rd_addr) < fill);
  end

  assign rd_data = hit_r ? q_r : 6'd0;

endmodule

/* hw/rtl/avsd_fields.sv */
// Field sequencer: reads sextets per field, extracts and emits one word per field.
// Depends on avsd_pkg.
module avsd_fields import avsd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic [5:0]         rd_data,
  output logic [4:0]         rd_addr,
  output logic               busy,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_msg_kind,
  output logic [4:0]         out_field_index,
  output logic signed [30:0] out_field_value,
  output logic               out_last_field
);

  typedef enum logic [3:0] {
    F_IDLE, F_ID_RD, F_ID_WT, F_PART_RD, F_PART_WT, F_LOAD, F_RD, F_WT, F_CALC, F_OUT
  } fstate_t;

  fstate_t          st_r;
  logic [1:0]       kind_r;
  logic [4:0]       idx_r, sidx_r;
  logic [2:0]       left_r;
  logic [ACC_W-1:0] acc_r;
  logic             val_r, last_r;
  logic [30:0]      value_r;
  fld_desc_t        d;
  logic [ACC_W-1:0] shifted, mask, masked, fin;

  assign d = field_desc(kind_r, idx_r);

  always_comb begin
    shifted = acc_r >> d.pad;
    mask    = (ACC_W'(1) << d.len) - ACC_W'(1);
    masked  = shifted & mask;
    fin     = masked;
    if (d.sgn && masked[d.len - 5'd1]) fin = masked - (ACC_W'(1) << d.len);
    if (d.chr && masked < ACC_W'(32)) fin = masked | ACC_W'(64);
  end

  always_comb begin
    case (st_r)
      F_PART_RD: rd_addr = 5'd6;
      F_RD:      rd_addr = sidx_r;
      default:   rd_addr = 5'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= F_IDLE;
      val_r <= 1'b0;
    end else begin
      unique case (st_r)
        F_IDLE: if (go) st_r <= F_ID_RD;
        F_ID_RD: st_r <= F_ID_WT;
        F_ID_WT: begin
          idx_r <= '0;
          if (rd_data == MSG_ID_18) begin
            kind_r <= KIND_MSG18;
            st_r   <= F_LOAD;
          end else if (rd_data == MSG_ID_24) st_r <= F_PART_RD;
          else st_r <= F_IDLE;
        end
        F_PART_RD: st_r <= F_PART_WT;
        F_PART_WT: begin
          kind_r <= (rd_data[3:2] != 2'd0) ? KIND_MSG24B : KIND_MSG24A;
          st_r   <= F_LOAD;
        end
        F_LOAD: begin
          sidx_r <= d.first;
          left_r <= d.nsext;
          acc_r  <= '0;
          st_r   <= F_RD;
        end
        F_RD: st_r <= F_WT;
        F_WT: begin
          acc_r  <= {acc_r[ACC_W-7:0], rd_data};
          sidx_r <= sidx_r + 5'd1;
          left_r <= left_r - 3'd1;
          st_r   <= (left_r == 3'd1) ? F_CALC : F_RD;
        end
        F_CALC: begin
          value_r <= fin[30:0];
          last_r  <= (idx_r == field_count(kind_r) - 5'd1);
          val_r   <= 1'b1;
          st_r    <= F_OUT;
        end
        F_OUT: begin
          if (!out_stall) begin
            val_r <= 1'b0;
            idx_r <= idx_r + 5'd1;
            st_r  <= last_r ? F_IDLE : F_LOAD;
          end
        end
        default: st_r <= F_IDLE;
      endcase
    end
  end

  assign busy            = (st_r != F_IDLE);
  assign out_valid       = val_r;
  assign out_msg_kind    = kind_r;
  assign out_field_index = idx_r;
  assign out_field_value = value_r;
  assign out_last_field  = last_r;

endmodule

/* hw/rtl/ais_vdm_sentence_decoder.sv */
// Top level of the AIS VDM sentence decoder: parser, sextet memory, field sequencer.
// Depends on avsd_pkg, avsd_parser, avsd_store, avsd_fields.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | char_byte, sentence_start
//  out_    | output    | out_valid/out_stall| msg_kind, field_index, field_value, last_field
//
// One character word per cycle is taken while no field run is in progress.
// The payload-ending comma starts a run: the id, and for type 24 the part, are fetched first; then
// per field come a load, one memory read and wait per sextet, a calc and an output word.
// in_stall stays high for the whole run. A stalled output word holds its field.
// Reset is synchronous; the store needs no clearing, a fill count masks unwritten entries.
module ais_vdm_sentence_decoder import avsd_pkg::*; #(
  parameter int PAYLOAD_SEXTETS = 28
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_char_byte,
  input  logic               in_sentence_start,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_msg_kind,
  output logic [4:0]         out_field_index,
  output logic signed [30:0] out_field_value,
  output logic               out_last_field
);

  localparam int AW = $clog2(PAYLOAD_SEXTETS);
  localparam int CW = $clog2(PAYLOAD_SEXTETS + 1);

  logic          accept, busy, wr_en, go;
  logic [AW-1:0] wr_addr;
  logic [5:0]    wr_data, rd_data;
  logic [CW-1:0] fill;
  logic [4:0]    rd_addr;

  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  avsd_parser #(.P(PAYLOAD_SEXTETS), .AW(AW), .CW(CW)) u_parser (
    .clk, .rst_n, .accept,
    .char_byte(in_char_byte), .sentence_start(in_sentence_start),
    .wr_en, .wr_addr, .wr_data, .fill, .go
  );

  avsd_store #(.P(PAYLOAD_SEXTETS), .AW(AW), .CW(CW)) u_store (
    .clk, .wr_en, .wr_addr, .wr_data,
    .rd_addr(AW'(rd_addr)), .fill, .rd_data
  );

  avsd_fields u_fields (
    .clk, .rst_n, .go, .rd_data, .rd_addr, .busy,
    .out_valid, .out_stall, .out_msg_kind, .out_field_index,
    .out_field_value, .out_last_field
  );

  a_stall_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken during field run");

  a_gap_after_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall) |=> !out_valid) else $error("back-to-back field words");

  a_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_field_index == 5'd0) |-> !out_last_field)
    else $error("run ended on first field");

endmodule

/* dv/testbench.sv */
// Self-checking bench for ais_vdm_sentence_decoder: drives sentence characters,
// predicts the field run of each payload and compares every output word.
// Depends on avsd_pkg and the decoder RTL.
`timescale 1ns / 1ps
module testbench;
  import avsd_pkg::*;

  typedef struct {
    logic [1:0]  kind;
    logic [4:0]  idx;
    logic [30:0] val;
    logic        last;
  } field_t;

  typedef enum int {PH_IDLE, PH_HEADER, PH_FIELDS, PH_PAYLOAD, PH_DONE} tb_phase_t;

  localparam int NSEXT = 28;
  localparam int LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_char_byte = 8'h00;
  logic in_sentence_start = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_msg_kind;
  logic [4:0] out_field_index;
  logic signed [30:0] out_field_value;
  logic out_last_field;

  ais_vdm_sentence_decoder dut (.*);

  always #4 clk = ~clk;

  // predictor state
  tb_phase_t p_phase = PH_IDLE;
  int        p_hpos, p_commas, p_count;
  logic [5:0] p_sext [NSEXT];
  field_t    fields_due [$];

  int send_idle_pct = 0, recv_idle_pct = 0;
  int n_bad = 0;
  int cycles = 0;

  function automatic logic [5:0] dearm(logic [7:0] c);
    int t;
    t = c + 40;
    t = (t > 128) ? t + 32 : t + 40;
    return t[5:0];
  endfunction

  function automatic logic [31:0] sx(int i);
    return (i < NSEXT) ? 32'(p_sext[i]) : 32'd0;
  endfunction

  function automatic logic [30:0] sext_val(logic [31:0] raw, int bits);
    logic [31:0] r;
    r = raw;
    if (raw[bits-1]) r = raw - (32'd1 << bits);
    return r[30:0];
  endfunction

  task automatic emit(logic [1:0] kind, logic [31:0] v[$]);
    field_t f;
    foreach (v[k]) begin
      f.kind = kind; f.idx = 5'(k); f.val = v[k][30:0];
      f.last = (k == v.size() - 1);
      fields_due.push_back(f);
    end
  endtask

  task automatic decode_payload();
    logic [31:0] v[$];
    logic [31:0] id, c;
    id = sx(0);
    v.push_back(id);
    v.push_back(sx(1) >> 4);
    v.push_back(((sx(1) & 15) << 26) | (sx(2) << 20) | (sx(3) << 14) | (sx(4) << 8) |
                (sx(5) << 2) | (sx(6) >> 4));
    if (id == 18) begin
      v.push_back(((sx(6) & 15) << 4) | (sx(7) >> 2));
      v.push_back(((sx(7) & 3) << 8) | (sx(8) << 2) | (sx(9) >> 4));
      v.push_back((sx(9) & 8) >> 3);
      v.push_back(sext_val(((sx(9) & 7) << 25) | (sx(10) << 19) | (sx(11) << 13) |
                           (sx(12) << 7) | (sx(13) << 1) | (sx(14) >> 5), 28));
      v.push_back(sext_val(((sx(14) & 31) << 22) | (sx(15) << 16) | (sx(16) << 10) |
                           (sx(17) << 4) | (sx(18) >> 2), 27));
      v.push_back(((sx(18) & 3) << 10) | (sx(19) << 4) | (sx(20) >> 2));
      v.push_back(((sx(20) & 3) << 7) | (sx(21) << 1) | (sx(22) >> 5));
      v.push_back(((sx(22) & 31) << 1) | (sx(23) >> 5));
      v.push_back((sx(23) & 24) >> 3);
      v.push_back((sx(23) >> 2) & 1);
      v.push_back((sx(23) >> 1) & 1);
      v.push_back(sx(23) & 1);
      for (int b = 5; b >= 1; b--) v.push_back((sx(24) >> b) & 1);
      v.push_back(((sx(24) & 1) << 18) | (sx(25) << 12) | (sx(26) << 6) | sx(27));
      emit(KIND_MSG18, v);
    end else if (id == 24) begin
      v.push_back((sx(6) & 12) >> 2);
      if ((sx(6) & 12) != 0) begin
        v.push_back(((sx(6) & 3) << 6) | sx(7));
        emit(KIND_MSG24B, v);
      end else begin
        for (int i = 0; i < 20; i++) begin
          c = ((sx(6 + i) & 3) << 4) | (sx(7 + i) >> 2);
          if (c < 32) c |= 64;
          v.push_back(c);
        end
        emit(KIND_MSG24A, v);
      end
    end
  endtask

  task automatic predict_char(logic [7:0] c, logic start);
    logic ok;
    if (start) begin
      p_phase = PH_HEADER; p_hpos = 0; p_commas = 0; p_count = 0;
      foreach (p_sext[i]) p_sext[i] = '0;
    end
    case (p_phase)
      PH_HEADER: begin
        ok = (p_hpos == 0) ? (c == CH_BANG || c == CH_DOLLAR) : (c == hdr_char(3'(p_hpos)));
        if (!ok) p_phase = PH_DONE;
        else begin
          p_hpos++;
          if (p_hpos >= 6) p_phase = PH_FIELDS;
        end
      end
      PH_FIELDS: if (c == CH_COMMA) begin
        p_commas++;
        if (p_commas >= 5) p_phase = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (c != CH_COMMA) begin
          if (p_count < NSEXT) begin
            p_sext[p_count] = dearm(c);
            p_count++;
          end
        end else begin
          p_phase = PH_DONE;
          decode_payload();
        end
      end
      default: ;
    endcase
  endtask

  // one character word through the input handshake; valid stays up between
  // back-to-back words and drops only for an idle gap
  task automatic send_char(logic [7:0] c, logic start);
    int gap;
    gap = 0;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_byte <= c;
    in_sentence_start <= start;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_char(c, start);
  endtask

  task automatic send_text(string s, logic start);
    for (int i = 0; i < s.len(); i++) send_char(s[i], start && i == 0);
  endtask

  // armored character for a six-bit value
  function automatic logic [7:0] armor(logic [5:0] v);
    return (v < 40) ? 8'(v + 48) : 8'(v + 56);
  endfunction

  task automatic send_sentence(logic [5:0] pl[$], logic good_hdr, logic terminate);
    send_text(good_hdr ? (($urandom_range(1)) ? "!AIVDM" : "$AIVDM") : "!AIVDX", 1'b1);
    send_text(",,,,,", 1'b0);
    foreach (pl[i]) send_char(armor(pl[i]), 1'b0);
    if (terminate) send_text(",", 1'b0);
  endtask

  function automatic void rand_payload(ref logic [5:0] pl[$], input int id, int n);
    pl.delete();
    for (int i = 0; i < n; i++) pl.push_back(6'($urandom_range(63)));
    if (n > 0) pl[0] = 6'(id);
  endfunction

  // checker
  always @(posedge clk) begin
    field_t e;
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (fields_due.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected field idx %0d val %0d", out_field_index,
                                  out_field_value);
      end else begin
        e = fields_due.pop_front();
        if (out_msg_kind !== e.kind || out_field_index !== e.idx ||
            out_field_value !== e.val || out_last_field !== e.last) begin
          n_bad++;
          if (n_bad <= 10)
            $display("mismatch: exp kind %0d idx %0d val %h last %0b, got %0d %0d %h %0b",
                     e.kind, e.idx, e.val, e.last, out_msg_kind, out_field_index,
                     out_field_value, out_last_field);
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
  end

  task automatic test_directed();
    logic [5:0] pl[$];
    send_text("X", 1'b0);                         // no sentence started
    pl = {}; for (int i = 0; i < 20; i++) pl.push_back(6'd63); pl[0] = 6'd18;
    send_sentence(pl, 1'b1, 1'b1);                // all ones, negative lat/lon
    pl = {}; for (int i = 0; i < 29; i++) pl.push_back(6'(i + 20)); pl[0] = 6'd24;
    pl[6] = 6'd0;
    send_sentence(pl, 1'b1, 1'b1);                // too long, part A
    pl = {6'd5, 6'd1};
    send_sentence(pl, 1'b1, 1'b1);                // other type
    send_text("!AIVDX,", 1'b1);                   // bad header
    send_text("!AI", 1'b1);
    send_text("$AIVDM,,,,,", 1'b1);               // restart mid sentence
    send_char(armor(6'd18), 1'b0);                // short payload, unreceived read zero
    send_text(",0*", 1'b0);                       // after payload
  endtask

  task automatic test_random(int n_items);
    logic [5:0] pl[$];
    int ids[3] = '{18, 24, 24};
    int sent;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) < 8) begin
        rand_payload(pl, ids[$urandom_range(2)], $urandom_range(1, 32));
        if (pl.size() > 6 && pl[0] == 24 && $urandom_range(1)) pl[6] = pl[6] & 6'h33;
        send_sentence(pl, 1'b1, 1'b1);
        sent += pl.size() + 12;
      end else begin
        rand_payload(pl, $urandom_range(63), $urandom_range(0, 8));
        send_sentence(pl, $urandom_range(1), $urandom_range(1));
        repeat (4) send_char(8'($urandom_range(255)), $urandom_range(7) == 0);
        sent += pl.size() + 16;
      end
    end
    send_text("!", 1'b1);                         // leaves no run pending
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (fields_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    send_idle_pct = 34; recv_idle_pct = 74;
    test_random(12);
    send_idle_pct = 74; recv_idle_pct = 34;
    test_random(12);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(12);
    drain();
    if (n_bad == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

/* files.f */
hw/rtl/avsd_pkg.sv
hw/rtl/avsd_parser.sv
hw/rtl/avsd_store.sv
hw/rtl/avsd_fields.sv
hw/rtl/ais_vdm_sentence_decoder.sv
dv/testbench.sv
